// ----- src/vrtp_pkg.sv -----
// ----------------------------------------------------------------------------
// vrtp_pkg
// Shared constants, state type and controller/datapath command and status
// structs for the voxel ray traversal picker.
// ----------------------------------------------------------------------------
package vrtp_pkg;

    localparam int GRID_DEF   = 16;
    localparam int FRAC_BITS  = 12;
    localparam int DIR_FRAC   = 14;
    localparam int COORD_W    = 16;
    localparam int DIR_W      = 16;
    localparam int VAL_W      = 8;
    localparam int PICK_W     = 4;
    localparam int IP_W       = COORD_W - FRAC_BITS;
    localparam int DIST_W     = FRAC_BITS + 1;
    localparam int NUM_W      = DIST_W + DIR_FRAC;
    localparam int MAG_W      = DIR_W;
    localparam int TINY_RECIP = 100000;
    localparam int TINY_W     = 17;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_TRACE = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_LOOK,
        ST_TEST
    } t_state;

    typedef struct packed {
        logic clear_wr;
        logic vox_wr;
        logic load;
        logic take_div;
        logic rd;
        logic advance;
        logic emit;
        logic emit_found;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
        logic div_done;
        logic stop;
        logic hit;
        logic out_full;
    } t_dp_stat;

endpackage

// ----- src/vrtp_div.sv -----
// ----------------------------------------------------------------------------
// vrtp_div
// Restoring divider, one quotient bit per cycle, two lanes sharing a divisor.
// ----------------------------------------------------------------------------
module vrtp_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [vrtp_pkg::NUM_W-1:0]  i_num_max,
    input  logic [vrtp_pkg::NUM_W-1:0]  i_num_delta,
    input  logic [vrtp_pkg::MAG_W-1:0]  i_div,
    output logic                        o_done,
    output logic [vrtp_pkg::NUM_W-1:0]  o_q_max,
    output logic [vrtp_pkg::NUM_W-1:0]  o_q_delta
);
    import vrtp_pkg::*;

    localparam int CW = $clog2(NUM_W);

    logic              r_run;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [MAG_W-1:0]  r_div;
    logic [NUM_W-1:0]  r_nq  [2];
    logic [MAG_W-1:0]  r_rem [2];
    logic [MAG_W:0]    sh    [2];
    logic [MAG_W:0]    diff  [2];
    logic              ge    [2];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            sh[l]   = {r_rem[l], r_nq[l][NUM_W-1]};
            ge[l]   = sh[l] >= {1'b0, r_div};
            diff[l] = sh[l] - {1'b0, r_div};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_run  <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_run) begin
            if (r_cnt == CW'(NUM_W - 1)) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_nq[0]  <= i_num_max;
            r_nq[1]  <= i_num_delta;
            r_rem[0] <= '0;
            r_rem[1] <= '0;
            r_div    <= i_div;
        end else if (r_run) begin
            for (int l = 0; l < 2; l++) begin
                r_rem[l] <= ge[l] ? diff[l][MAG_W-1:0] : sh[l][MAG_W-1:0];
                r_nq[l]  <= {r_nq[l][NUM_W-2:0], ge[l]};
            end
        end
    end

    assign o_done    = r_done;
    assign o_q_max   = r_nq[0];
    assign o_q_delta = r_nq[1];

endmodule

// ----- src/vrtp_ctrl.sv -----
// ----------------------------------------------------------------------------
// vrtp_ctrl
// Sequencer: clear sweep, request intake, division wait, DDA step loop.
// ----------------------------------------------------------------------------
module vrtp_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_cmd,
    input  vrtp_pkg::t_dp_stat i_stat,
    output logic               o_ready,
    output vrtp_pkg::t_dp_cmd  o_dp_cmd
);
    import vrtp_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_ready  = 1'b0;
        o_dp_cmd = '0;
        case (r_state)
            ST_CLEAR: begin
                o_dp_cmd.clear_wr = 1'b1;
                if (i_stat.clear_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_cmd == CMD_TRACE) begin
                        o_dp_cmd.load = 1'b1;
                        n_state       = ST_DIV;
                    end else begin
                        o_dp_cmd.vox_wr = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                if (i_stat.div_done) begin
                    o_dp_cmd.take_div = 1'b1;
                    n_state           = ST_LOOK;
                end
            end
            ST_LOOK: begin
                o_dp_cmd.rd = 1'b1;
                n_state     = ST_TEST;
            end
            ST_TEST: begin
                // hold while the previous result is still waiting
                if (!i_stat.out_full) begin
                    if (i_stat.stop) begin
                        o_dp_cmd.emit = 1'b1;
                        n_state       = ST_IDLE;
                    end else if (i_stat.hit) begin
                        o_dp_cmd.emit       = 1'b1;
                        o_dp_cmd.emit_found = 1'b1;
                        n_state             = ST_IDLE;
                    end else begin
                        o_dp_cmd.advance = 1'b1;
                        n_state          = ST_LOOK;
                    end
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

endmodule

// ----- src/vrtp_dp.sv -----
// ----------------------------------------------------------------------------
// vrtp_dp
// Datapath: voxel memory, per-axis setup and dividers, DDA walk registers,
// result register.
// ----------------------------------------------------------------------------
module vrtp_dp #(
    parameter int GRID = vrtp_pkg::GRID_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  vrtp_pkg::t_dp_cmd                 i_dp_cmd,
    output vrtp_pkg::t_dp_stat                o_stat,
    input  logic [vrtp_pkg::COORD_W-1:0]      i_start_x,
    input  logic [vrtp_pkg::COORD_W-1:0]      i_start_y,
    input  logic [vrtp_pkg::COORD_W-1:0]      i_start_z,
    input  logic [vrtp_pkg::COORD_W-1:0]      i_end_x,
    input  logic [vrtp_pkg::COORD_W-1:0]      i_end_y,
    input  logic [vrtp_pkg::COORD_W-1:0]      i_end_z,
    input  logic signed [vrtp_pkg::DIR_W-1:0] i_dir_x,
    input  logic signed [vrtp_pkg::DIR_W-1:0] i_dir_y,
    input  logic signed [vrtp_pkg::DIR_W-1:0] i_dir_z,
    input  logic [vrtp_pkg::VAL_W-1:0]        i_voxel_value,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic                              o_found,
    output logic [vrtp_pkg::PICK_W-1:0]       o_pick_x,
    output logic [vrtp_pkg::PICK_W-1:0]       o_pick_y,
    output logic [vrtp_pkg::PICK_W-1:0]       o_pick_z
);
    import vrtp_pkg::*;

    localparam int DEPTH  = GRID * GRID * GRID;
    localparam int AW     = $clog2(DEPTH);
    localparam int LIMIT  = 3 * GRID;
    localparam int CNT_W  = $clog2(LIMIT + 1);
    localparam int IDX_W  = $clog2(LIMIT + (1 << IP_W)) + 2;
    localparam int TIME_W = DIST_W + TINY_W + $clog2(LIMIT + 2);

    logic [VAL_W-1:0] mem [DEPTH];
    logic [VAL_W-1:0] r_rd_data;
    logic [AW-1:0]    r_clr;

    logic [COORD_W-1:0]     s_in     [3];
    logic [COORD_W-1:0]     e_in     [3];
    logic [DIR_W-1:0]       d_in     [3];
    logic [IP_W-1:0]        ip       [3];
    logic [MAG_W-1:0]       mag      [3];
    logic [DIST_W-1:0]      bnd_dist [3];
    logic [NUM_W-1:0]       q_max    [3];
    logic [NUM_W-1:0]       q_del    [3];
    logic [2:0]             done;
    logic [2:0]             in_grid;
    logic [2:0]             at_end;
    logic [2:0]             wr_in;
    logic [1:0]             sel;

    logic signed [IDX_W-1:0] r_idx    [3];
    logic                    r_neg    [3];
    logic                    r_zero   [3];
    logic [TIME_W-1:0]       r_tiny   [3];
    logic [IP_W-1:0]         r_end    [3];
    logic [TIME_W-1:0]       r_tmax   [3];
    logic [TIME_W-1:0]       r_tdelta [3];
    logic [CNT_W-1:0]        r_n;
    logic                    r_o_valid;

    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    always_comb begin
        s_in[0] = i_start_x;  s_in[1] = i_start_y;  s_in[2] = i_start_z;
        e_in[0] = i_end_x;    e_in[1] = i_end_y;    e_in[2] = i_end_z;
        d_in[0] = i_dir_x;    d_in[1] = i_dir_y;    d_in[2] = i_dir_z;
        for (int a = 0; a < 3; a++) begin
            ip[a]    = s_in[a][COORD_W-1:FRAC_BITS];
            mag[a]   = d_in[a][DIR_W-1] ? (MAG_W'(0) - d_in[a]) : d_in[a];
            bnd_dist[a] = d_in[a][DIR_W-1] ? {1'b0, s_in[a][FRAC_BITS-1:0]}
                     : (DIST_W'(1 << FRAC_BITS) - {1'b0, s_in[a][FRAC_BITS-1:0]});
            wr_in[a] = 32'(ip[a]) < GRID;
            in_grid[a] = !r_idx[a][IDX_W-1] && (r_idx[a] < $signed(IDX_W'(GRID)));
            at_end[a]  = r_idx[a] == $signed(IDX_W'(r_end[a]));
        end
        wr_addr = AW'(AW'(ip[0]) * AW'(GRID) * AW'(GRID) + AW'(ip[1]) * AW'(GRID)
                + AW'(ip[2]));
        rd_addr = AW'(AW'($unsigned(r_idx[0])) * AW'(GRID) * AW'(GRID)
                + AW'($unsigned(r_idx[1])) * AW'(GRID) + AW'($unsigned(r_idx[2])));
        // smallest tmax; ties go to z, then y over x
        if (r_tmax[0] < r_tmax[1]) begin
            sel = (r_tmax[0] < r_tmax[2]) ? 2'd0 : 2'd2;
        end else begin
            sel = (r_tmax[1] < r_tmax[2]) ? 2'd1 : 2'd2;
        end
    end

    for (genvar a = 0; a < 3; a++) begin : g_axis
        vrtp_div u_div (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_start     (i_dp_cmd.load),
            .i_num_max   ({bnd_dist[a], DIR_FRAC'(0)}),
            .i_num_delta (NUM_W'(1) << (FRAC_BITS + DIR_FRAC)),
            .i_div       (mag[a]),
            .o_done      (done[a]),
            .o_q_max     (q_max[a]),
            .o_q_delta   (q_del[a])
        );
    end

    // memory: clear sweep and voxel writes share the write port
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.clear_wr) begin
            mem[r_clr] <= '0;
        end else if (i_dp_cmd.vox_wr && (&wr_in)) begin
            mem[wr_addr] <= i_voxel_value;
        end
        if (i_dp_cmd.rd) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_dp_cmd.clear_wr) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load) begin
            r_n <= '0;
            for (int a = 0; a < 3; a++) begin
                r_idx[a]  <= $signed(IDX_W'(ip[a]));
                r_neg[a]  <= d_in[a][DIR_W-1];
                r_zero[a] <= mag[a] == '0;
                r_tiny[a] <= TIME_W'(bnd_dist[a]) * TIME_W'(TINY_RECIP);
                r_end[a]  <= e_in[a][COORD_W-1:FRAC_BITS];
            end
        end else if (i_dp_cmd.take_div) begin
            for (int a = 0; a < 3; a++) begin
                r_tmax[a]   <= r_zero[a] ? r_tiny[a] : TIME_W'(q_max[a]);
                r_tdelta[a] <= r_zero[a] ? (TIME_W'(TINY_RECIP) << FRAC_BITS)
                                         : TIME_W'(q_del[a]);
            end
        end else if (i_dp_cmd.advance) begin
            r_n          <= r_n + 1'b1;
            r_idx[sel]   <= r_neg[sel] ? (r_idx[sel] - $signed(IDX_W'(1)))
                                       : (r_idx[sel] + $signed(IDX_W'(1)));
            r_tmax[sel]  <= r_tmax[sel] + r_tdelta[sel];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_dp_cmd.emit) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.emit) begin
            o_found  <= i_dp_cmd.emit_found;
            o_pick_x <= i_dp_cmd.emit_found ? r_idx[0][PICK_W-1:0] : PICK_W'(r_end[0]);
            o_pick_y <= i_dp_cmd.emit_found ? r_idx[1][PICK_W-1:0] : PICK_W'(r_end[1]);
            o_pick_z <= i_dp_cmd.emit_found ? r_idx[2][PICK_W-1:0] : PICK_W'(r_end[2]);
        end
    end

    assign o_out_valid       = r_o_valid;
    assign o_stat.clear_last = r_clr == AW'(DEPTH - 1);
    assign o_stat.div_done   = &done;
    assign o_stat.stop       = (r_n == CNT_W'(LIMIT)) || (&at_end);
    assign o_stat.hit        = (&in_grid) && (r_rd_data != '0);
    assign o_stat.out_full   = r_o_valid;

endmodule

// ----- src/voxel_ray_traversal_picker_core.sv -----
// Operation: a write request is stored in memory in its accept cycle; a trace
//   loads, runs the dividers, seeds tmax/tdelta, then reads and tests each voxel.
// Requests: one at a time; a trace blocks new requests until it has emitted its
//   result, its time set by the serial divider and the memory read per step.
// Reset: synchronous, active low; then a clearing sweep zeroes all GRID^3 (4096)
//   voxel memory entries while o_ready stays low.
// ----------------------------------------------------------------------------
// voxel_ray_traversal_picker_core
// 3D DDA voxel picker: stores voxels on write requests and walks a ray
// through the grid on trace requests, reporting the first occupied voxel.
// ----------------------------------------------------------------------------
module voxel_ray_traversal_picker_core #(
    parameter int GRID = vrtp_pkg::GRID_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request channel
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_cmd,
    input  logic [vrtp_pkg::COORD_W-1:0]      i_start_x,
    input  logic [vrtp_pkg::COORD_W-1:0]      i_start_y,
    input  logic [vrtp_pkg::COORD_W-1:0]      i_start_z,
    input  logic [vrtp_pkg::COORD_W-1:0]      i_end_x,
    input  logic [vrtp_pkg::COORD_W-1:0]      i_end_y,
    input  logic [vrtp_pkg::COORD_W-1:0]      i_end_z,
    input  logic signed [vrtp_pkg::DIR_W-1:0] i_dir_x,
    input  logic signed [vrtp_pkg::DIR_W-1:0] i_dir_y,
    input  logic signed [vrtp_pkg::DIR_W-1:0] i_dir_z,
    input  logic [vrtp_pkg::VAL_W-1:0]        i_voxel_value,
    // result channel
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_found,
    output logic [vrtp_pkg::PICK_W-1:0]       o_pick_x,
    output logic [vrtp_pkg::PICK_W-1:0]       o_pick_y,
    output logic [vrtp_pkg::PICK_W-1:0]       o_pick_z
);
    import vrtp_pkg::*;

    // Controller and datapath talk only through these two bundles.
    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Controller: clear sweep after reset, then accept one request at a time.
    // A write lands in memory in the accept cycle; a trace starts the three
    // axis dividers, then loops read-voxel / test-and-advance until a hit,
    // the end voxel, or the 3*GRID step limit.
    vrtp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_cmd    (i_cmd),
        .i_stat   (dp_stat),
        .o_ready  (o_ready),
        .o_dp_cmd (dp_cmd)
    );

    // Datapath: voxel memory, per-axis tmax/tdelta setup, walk state and the
    // result register that holds a pick until the consumer takes it.
    vrtp_dp #(
        .GRID (GRID)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_dp_cmd      (dp_cmd),
        .o_stat        (dp_stat),
        .i_start_x     (i_start_x),
        .i_start_y     (i_start_y),
        .i_start_z     (i_start_z),
        .i_end_x       (i_end_x),
        .i_end_y       (i_end_y),
        .i_end_z       (i_end_z),
        .i_dir_x       (i_dir_x),
        .i_dir_y       (i_dir_y),
        .i_dir_z       (i_dir_z),
        .i_voxel_value (i_voxel_value),
        .i_out_ready   (i_ready),
        .o_out_valid   (o_valid),
        .o_found       (o_found),
        .o_pick_x      (o_pick_x),
        .o_pick_y      (o_pick_y),
        .o_pick_z      (o_pick_z)
    );

endmodule

// ----- src/vrtp_checker.sv -----
// ----------------------------------------------------------------------------
// vrtp_checker
// Port-level checks on the picker, attached to the top level by bind.
// ----------------------------------------------------------------------------
module vrtp_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_ready,
    input logic                        i_cmd,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic                        o_found,
    input logic [vrtp_pkg::PICK_W-1:0] o_pick_x
);
    import vrtp_pkg::*;

    // no request is taken during the first cycle after reset (clear sweep)
    a_clear_blocks: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_ready)
        else $error("request accepted before memory clear");

    // a write request never produces a result
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_cmd == CMD_WRITE) |=> !$rose(o_valid))
        else $error("result after write request");

    // a trace request keeps the block busy in the next cycle
    a_trace_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_cmd == CMD_TRACE) |=> !o_ready)
        else $error("request accepted during trace");

    // a pending result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_found) && $stable(o_pick_x)))
        else $error("result dropped or changed while stalled");

endmodule

bind voxel_ray_traversal_picker_core vrtp_checker u_vrtp_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (i_valid),
    .o_ready  (o_ready),
    .i_cmd    (i_cmd),
    .o_valid  (o_valid),
    .i_ready  (i_ready),
    .o_found  (o_found),
    .o_pick_x (o_pick_x)
);
